/* sv/swpm_pkg.sv */
// ----------------------------------------------------------------------------
// swpm_pkg
// Shared types and constants of the sliding-window pose MSE unit.
// ----------------------------------------------------------------------------
`default_nettype none

package swpm_pkg;

    localparam int POS_W       = 20;
    localparam int HEAD_W      = 16;
    localparam int POS_SQ_W    = 42;
    localparam int HEAD_SQ_W   = 33;
    localparam int MEAN_POS_W  = 41;
    localparam int MEAN_HEAD_W = 32;

    // register file
    localparam int          WL_W      = 7;
    localparam logic [6:0]  WL_RESET  = 7'd8;
    localparam int          APB_DW    = 32;
    localparam int          APB_AW    = 3;
    localparam logic [0:0]  REG_WINDOW_LENGTH = 1'b0;

    typedef struct packed {
        logic signed [POS_W-1:0]  true_x;
        logic signed [POS_W-1:0]  true_y;
        logic signed [HEAD_W-1:0] true_heading;
        logic signed [POS_W-1:0]  est_x;
        logic signed [POS_W-1:0]  est_y;
        logic signed [HEAD_W-1:0] est_heading;
    } t_pose_in;

    typedef struct packed {
        logic [MEAN_POS_W-1:0]  mean_sq_position_error;
        logic [MEAN_HEAD_W-1:0] mean_sq_heading_error;
    } t_mse_out;

endpackage

`default_nettype wire

/* sv/swpm_in_if.sv */
// ----------------------------------------------------------------------------
// swpm_in_if
// Valid/ready channel carrying one pose pair per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface swpm_in_if import swpm_pkg::*; ();
    logic     valid;
    logic     ready;
    t_pose_in data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/swpm_out_if.sv */
// ----------------------------------------------------------------------------
// swpm_out_if
// Valid/ready channel carrying the two window means per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface swpm_out_if import swpm_pkg::*; ();
    logic     valid;
    logic     ready;
    t_mse_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/swpm_ram.sv */
// ----------------------------------------------------------------------------
// swpm_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module swpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* sv/swpm_sq_mul.sv */
// ----------------------------------------------------------------------------
// swpm_sq_mul
// Bit-serial squarer: one multiplier bit per cycle, shift and add.
// ----------------------------------------------------------------------------
`default_nettype none

module swpm_sq_mul #(
    parameter int W = 21
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [W-1:0]   i_operand,
    output logic                o_busy,
    output logic [2*W-1:0]      o_square
);

    localparam int CNT_W = $clog2(W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [2*W-1:0]   r_mcand;
    logic [W-1:0]     r_mplier;
    logic [2*W-1:0]   r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand  <= {{W{1'b0}}, i_operand};
            r_mplier <= i_operand;
            r_acc    <= '0;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= {r_mcand[2*W-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[W-1:1]};
        end
    end

    assign o_busy   = r_busy;
    assign o_square = r_acc;

endmodule

`default_nettype wire

/* sv/swpm_div.sv */
// ----------------------------------------------------------------------------
// swpm_div
// Bit-serial restoring divider: one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
`default_nettype none

module swpm_div #(
    parameter int NW = 48,
    parameter int DW = 7
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_dividend,
    input  wire logic [DW-1:0] i_divisor,
    output logic               o_busy,
    output logic [NW-1:0]      o_quotient
);

    localparam int CNT_W = $clog2(NW + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_dvs;
    logic [NW-1:0]    r_quo;
    logic [DW:0]      shifted;
    logic [DW:0]      trial;

    // remainder stays below the divisor, so one extra bit covers the shift
    assign shifted = {r_rem, r_quo[NW-1]};
    assign trial   = shifted - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(NW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            if (!trial[DW]) begin
                r_rem <= trial[DW-1:0];
                r_quo <= {r_quo[NW-2:0], 1'b1};
            end else begin
                r_rem <= shifted[DW-1:0];
                r_quo <= {r_quo[NW-2:0], 1'b0};
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

/* sv/sliding_window_pose_mse_unit.sv */
// ----------------------------------------------------------------------------
// sliding_window_pose_mse_unit
// Mean squared position and heading error over a sliding window of poses.
// ----------------------------------------------------------------------------
// One transaction at a time: a pose pair is taken, squared errors are formed
// by bit-serial squarers, the running window sums are updated in place
// against the ring RAMs, and both sums are divided by the fill count in
// bit-serial dividers, one quotient bit per cycle. The sequencer waits in
// S_MUL for the squarers, then steps through S_SUB, S_ADD and S_DSTART to
// S_DIV, whose wait is set mostly by the divider of the position sum. It returns to
// idle, ready for the next pose, in the same cycle that the result becomes
// valid, so a pose is taken only once the last one has left the dividers.
// The result sits in an output register, so the next pose is taken while it
// waits; a second result then holds in the divider stage until the first is
// taken. The rings are not cleared after reset; the fill count keeps unwritten
// entries out of the sums. Writing window_length restarts the window empty.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_pose_mse_unit import swpm_pkg::*; #(
    parameter int WINDOW_MAX = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    swpm_in_if.sink                i_pose,
    swpm_out_if.source             o_mse,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    localparam int SW    = $clog2(WINDOW_MAX);
    localparam int CW    = $clog2(WINDOW_MAX + 1);
    localparam int PSW   = POS_SQ_W + SW;
    localparam int HSW   = HEAD_SQ_W + SW;
    localparam int PMAG  = POS_W + 1;
    localparam int HMAG  = HEAD_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SUB,
        S_ADD,
        S_DSTART,
        S_DIV
    } t_state;

    t_state              r_state;
    logic [WL_W-1:0]     r_wl;
    logic [SW-1:0]       r_slot;
    logic [CW-1:0]       r_filled;
    logic [PSW-1:0]      r_psum;
    logic [HSW-1:0]      r_hsum;
    logic [POS_SQ_W-1:0] r_new_p;
    logic [HEAD_SQ_W-1:0] r_new_h;
    logic                r_out_valid;
    t_mse_out            r_out;

    logic                cfg_wr;
    logic                in_acc;
    logic                out_free;
    logic                res_load;
    logic [CW-1:0]       eff_w;
    logic [CW-1:0]       slot_inc;
    logic [SW-1:0]       n_slot;

    logic [PMAG-1:0]     dx;
    logic [PMAG-1:0]     dy;
    logic [HMAG-1:0]     dh;
    logic [PMAG-1:0]     mag_x;
    logic [PMAG-1:0]     mag_y;
    logic [HMAG-1:0]     mag_h;
    logic                busy_x;
    logic                busy_y;
    logic                busy_h;
    logic [2*PMAG-1:0]   sq_x;
    logic [2*PMAG-1:0]   sq_y;
    logic [2*HMAG-1:0]   sq_h;

    logic [POS_SQ_W-1:0]  rd_p;
    logic [HEAD_SQ_W-1:0] rd_h;
    logic                 ram_we;

    logic                div_start;
    logic                busy_dp;
    logic                busy_dh;
    logic [PSW-1:0]      quo_p;
    logic [HSW-1:0]      quo_h;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[2] == REG_WINDOW_LENGTH);
    assign prdata = (paddr[2] == REG_WINDOW_LENGTH) ? APB_DW'(r_wl) : '0;

    always_comb begin
        if (r_wl == '0) begin
            eff_w = CW'(1);
        end else if (32'(r_wl) > 32'(WINDOW_MAX)) begin
            eff_w = CW'(WINDOW_MAX);
        end else begin
            eff_w = CW'(r_wl);
        end
    end

    assign slot_inc = CW'(r_slot) + CW'(1);
    assign n_slot   = (slot_inc >= eff_w) ? '0 : slot_inc[SW-1:0];

    // ---------------- error magnitudes ----------------
    assign dx = {i_pose.data.est_x[POS_W-1], i_pose.data.est_x}
              - {i_pose.data.true_x[POS_W-1], i_pose.data.true_x};
    assign dy = {i_pose.data.est_y[POS_W-1], i_pose.data.est_y}
              - {i_pose.data.true_y[POS_W-1], i_pose.data.true_y};
    assign dh = {i_pose.data.est_heading[HEAD_W-1], i_pose.data.est_heading}
              - {i_pose.data.true_heading[HEAD_W-1], i_pose.data.true_heading};

    assign mag_x = dx[PMAG-1] ? (~dx + PMAG'(1)) : dx;
    assign mag_y = dy[PMAG-1] ? (~dy + PMAG'(1)) : dy;
    assign mag_h = dh[HMAG-1] ? (~dh + HMAG'(1)) : dh;

    assign in_acc = i_pose.valid && i_pose.ready;

    swpm_sq_mul #(.W(PMAG)) u_sq_x (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (in_acc),
        .i_operand (mag_x),
        .o_busy    (busy_x),
        .o_square  (sq_x)
    );

    swpm_sq_mul #(.W(PMAG)) u_sq_y (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (in_acc),
        .i_operand (mag_y),
        .o_busy    (busy_y),
        .o_square  (sq_y)
    );

    swpm_sq_mul #(.W(HMAG)) u_sq_h (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (in_acc),
        .i_operand (mag_h),
        .o_busy    (busy_h),
        .o_square  (sq_h)
    );

    // ---------------- ring buffers ----------------
    assign ram_we = (r_state == S_ADD);

    swpm_ram #(.WIDTH(POS_SQ_W), .DEPTH(WINDOW_MAX)) u_ring_pos (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (r_new_p),
        .i_raddr (r_slot),
        .o_rdata (rd_p)
    );

    swpm_ram #(.WIDTH(HEAD_SQ_W), .DEPTH(WINDOW_MAX)) u_ring_head (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (r_new_h),
        .i_raddr (r_slot),
        .o_rdata (rd_h)
    );

    // ---------------- dividers ----------------
    assign div_start = (r_state == S_DSTART);

    swpm_div #(.NW(PSW), .DW(CW)) u_div_pos (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_psum),
        .i_divisor  (r_filled),
        .o_busy     (busy_dp),
        .o_quotient (quo_p)
    );

    swpm_div #(.NW(HSW), .DW(CW)) u_div_head (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_hsum),
        .i_divisor  (r_filled),
        .o_busy     (busy_dh),
        .o_quotient (quo_h)
    );

    // ---------------- sequencer ----------------
    assign out_free = !r_out_valid || o_mse.ready;
    assign res_load = (r_state == S_DIV) && !busy_dp && !busy_dh && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wl        <= WL_RESET;
            r_slot      <= '0;
            r_filled    <= '0;
            r_psum      <= '0;
            r_hsum      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (o_mse.ready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_wr) begin
                // restart the window empty
                r_wl     <= pwdata[WL_W-1:0];
                r_slot   <= '0;
                r_filled <= '0;
                r_psum   <= '0;
                r_hsum   <= '0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (!busy_x && !busy_y && !busy_h) begin
                        r_new_p <= POS_SQ_W'(sq_x) + POS_SQ_W'(sq_y);
                        r_new_h <= sq_h[HEAD_SQ_W-1:0];
                        r_state <= S_SUB;
                    end
                end
                S_SUB: begin
                    // window full: the entry being overwritten leaves the sums
                    if (r_filled == eff_w) begin
                        r_psum <= r_psum - PSW'(rd_p);
                        r_hsum <= r_hsum - HSW'(rd_h);
                    end
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_psum <= r_psum + PSW'(r_new_p);
                    r_hsum <= r_hsum + HSW'(r_new_h);
                    if (r_filled < eff_w) begin
                        r_filled <= r_filled + CW'(1);
                    end
                    r_slot  <= n_slot;
                    r_state <= S_DSTART;
                end
                S_DSTART: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (res_load) begin
                        r_out.mean_sq_position_error <= quo_p[MEAN_POS_W-1:0];
                        r_out.mean_sq_heading_error  <= quo_h[MEAN_HEAD_W-1:0];
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_pose.ready = (r_state == S_IDLE);
    assign o_mse.valid  = r_out_valid;
    assign o_mse.data   = r_out;

endmodule

`default_nettype wire

/* sv/swpm_checker.sv */
// ----------------------------------------------------------------------------
// swpm_checker
// Port-level assertions for the sliding-window pose MSE unit, with bind.
// ----------------------------------------------------------------------------
`default_nettype none

module swpm_checker import swpm_pkg::*; (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_in_valid,
    input wire logic                   i_in_ready,
    input wire logic                   i_out_valid,
    input wire logic                   i_out_ready,
    input wire logic [MEAN_POS_W-1:0]  i_out_pos,
    input wire logic [MEAN_HEAD_W-1:0] i_out_head
);

    localparam logic [MEAN_POS_W-1:0]  POS_MAX  = 41'd2199019061250;
    localparam logic [MEAN_HEAD_W-1:0] HEAD_MAX = 32'hFFFE_0001;

    logic [2:0] r_pending;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // transactions taken but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + 3'(in_acc) - 3'(out_acc);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_pos) && $stable(i_out_head))
        else $error("stalled result changed");

    a_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending <= 3'd2) && (!i_out_valid || r_pending != 3'd0))
        else $error("result count does not match accepted transactions");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_pos <= POS_MAX) && (i_out_head <= HEAD_MAX))
        else $error("mean above largest possible squared error");

endmodule

bind sliding_window_pose_mse_unit swpm_checker u_swpm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pose.valid),
    .i_in_ready  (i_pose.ready),
    .i_out_valid (o_mse.valid),
    .i_out_ready (o_mse.ready),
    .i_out_pos   (o_mse.data.mean_sq_position_error),
    .i_out_head  (o_mse.data.mean_sq_heading_error)
);

`default_nettype wire

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sliding-window pose MSE unit: a stimulus table
// of directed poses, some with known results, and register writes, then random
// window settings and pose streams; others checked by a local window predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top import swpm_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW_DEPTH    = 64;
    localparam int RANDOM_ITEMS    = 900;
    localparam int SETTLE_CYCLES   = 10;
    localparam int END_CYCLES      = 100;
    localparam int HOLDOFF_CYCLES  = 400;
    localparam int WATCHDOG_LIMIT  = 5000;

    localparam int POS_MIN  = -524288;
    localparam int POS_MAX  = 524287;
    localparam int HEAD_MIN = -32768;
    localparam int HEAD_MAX = 32767;

    localparam logic [APB_AW-1:0] ADDR_WINDOW_LENGTH = APB_AW'(4 * int'(REG_WINDOW_LENGTH));
    // one past the last register: writes there must be dropped
    localparam logic [APB_AW-1:0] ADDR_NO_REG        = APB_AW'(4);

    typedef enum logic [0:0] {STEP_POSE, STEP_REG} t_step_kind;

    typedef struct {
        t_step_kind        kind;
        logic [APB_AW-1:0] addr;
        logic [APB_DW-1:0] wdata;
        t_pose_in          pose;
        bit                has_known;
        t_mse_out          known_mse;
    } t_step;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    swpm_in_if  pose_if ();
    swpm_out_if mse_if ();

    sliding_window_pose_mse_unit #(
        .WINDOW_MAX (WINDOW_DEPTH)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pose  (pose_if),
        .o_mse   (mse_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // window predictor state
    logic [WL_W-1:0]      wl_reg;
    logic [POS_SQ_W-1:0]  pos_err_ring  [WINDOW_DEPTH];
    logic [HEAD_SQ_W-1:0] head_err_ring [WINDOW_DEPTH];
    int unsigned          write_pos;
    int unsigned          fill_count;

    t_mse_out mse_expected [$];
    t_step    directed_steps [$];

    // expectation typed into the table, travels with the pose on the bus
    bit       pose_has_known;
    t_mse_out pose_known;

    bit  pose_gaps_on;
    int  errors;
    int  results_seen;
    int  holdoffs_done;
    int  poses_sent;
    int  stalled_cycles;

    wire pose_accept = pose_if.valid && pose_if.ready;
    wire mse_accept  = mse_if.valid && mse_if.ready;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic int unsigned window_span();
        if (wl_reg == '0)
            return 1;
        if (wl_reg > WINDOW_DEPTH)
            return WINDOW_DEPTH;
        return 32'(wl_reg);
    endfunction

    function automatic t_mse_out predict_window_means(t_pose_in p);
        logic [POS_W:0]       dx;
        logic [POS_W:0]       dy;
        logic [HEAD_W:0]      dh;
        logic [POS_SQ_W-1:0]  mx;
        logic [POS_SQ_W-1:0]  my;
        logic [HEAD_SQ_W-1:0] mh;
        logic [47:0]          pos_total;
        logic [38:0]          head_total;
        int unsigned          span;
        t_mse_out             r;
        dx = {p.est_x[POS_W-1], p.est_x} - {p.true_x[POS_W-1], p.true_x};
        dy = {p.est_y[POS_W-1], p.est_y} - {p.true_y[POS_W-1], p.true_y};
        dh = {p.est_heading[HEAD_W-1], p.est_heading}
           - {p.true_heading[HEAD_W-1], p.true_heading};
        mx = dx[POS_W] ? {21'd0, -dx} : {21'd0, dx};
        my = dy[POS_W] ? {21'd0, -dy} : {21'd0, dy};
        mh = dh[HEAD_W] ? {16'd0, -dh} : {16'd0, dh};
        span = window_span();
        if (fill_count < span)
            fill_count++;
        if (fill_count > span)
            fill_count = span;
        if (write_pos >= span)
            write_pos = 0;
        pos_err_ring[write_pos]  = mx * mx + my * my;
        head_err_ring[write_pos] = mh * mh;
        write_pos++;
        if (write_pos >= span)
            write_pos = 0;
        pos_total  = '0;
        head_total = '0;
        for (int i = 0; i < fill_count; i++) begin
            pos_total  += pos_err_ring[i];
            head_total += head_err_ring[i];
        end
        r.mean_sq_position_error = MEAN_POS_W'(pos_total / fill_count);
        r.mean_sq_heading_error  = MEAN_HEAD_W'(head_total / fill_count);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_step pose_row(int tx, int ty, int th, int ex, int ey, int eh,
                                       bit has_known, longint kpos, longint khead);
        t_step s;
        s.kind                             = STEP_POSE;
        s.addr                             = '0;
        s.wdata                            = '0;
        s.pose.true_x                      = POS_W'(tx);
        s.pose.true_y                      = POS_W'(ty);
        s.pose.true_heading                = HEAD_W'(th);
        s.pose.est_x                       = POS_W'(ex);
        s.pose.est_y                       = POS_W'(ey);
        s.pose.est_heading                 = HEAD_W'(eh);
        s.has_known                        = has_known;
        s.known_mse.mean_sq_position_error = MEAN_POS_W'(kpos);
        s.known_mse.mean_sq_heading_error  = MEAN_HEAD_W'(khead);
        return s;
    endfunction

    function automatic t_step reg_row(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
        t_step s;
        s           = pose_row(0, 0, 0, 0, 0, 0, 1'b0, 0, 0);
        s.kind      = STEP_REG;
        s.addr      = addr;
        s.wdata     = data;
        return s;
    endfunction

    function automatic void add_step(t_step s);
        directed_steps.insert(directed_steps.size(), s);
    endfunction

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 15);
        return $urandom_range(30, 120);
    endfunction

    function automatic t_pose_in rand_pose();
        t_pose_in    p;
        int unsigned pick;
        p.true_x       = POS_W'($urandom);
        p.true_y       = POS_W'($urandom);
        p.true_heading = HEAD_W'($urandom);
        p.est_x        = POS_W'($urandom);
        p.est_y        = POS_W'($urandom);
        p.est_heading  = HEAD_W'($urandom);
        pick = $urandom_range(0, 8);
        case (pick)
            5, 6: begin
                // tracking estimate: small errors
                p.est_x       = p.true_x + POS_W'($urandom_range(0, 128) - 64);
                p.est_y       = p.true_y + POS_W'($urandom_range(0, 128) - 64);
                p.est_heading = p.true_heading + HEAD_W'($urandom_range(0, 64) - 32);
            end
            7: begin
                p.true_x       = $urandom_range(0, 1) ? POS_W'(POS_MAX) : POS_W'(POS_MIN);
                p.true_y       = $urandom_range(0, 1) ? POS_W'(POS_MAX) : POS_W'(POS_MIN);
                p.true_heading = $urandom_range(0, 1) ? HEAD_W'(HEAD_MAX) : HEAD_W'(HEAD_MIN);
                p.est_x        = $urandom_range(0, 1) ? POS_W'(POS_MAX) : POS_W'(POS_MIN);
                p.est_y        = $urandom_range(0, 1) ? POS_W'(POS_MAX) : POS_W'(POS_MIN);
                p.est_heading  = $urandom_range(0, 1) ? HEAD_W'(HEAD_MAX) : HEAD_W'(HEAD_MIN);
            end
            8: begin
                p.est_x       = p.true_x;
                p.est_y       = p.true_y;
                p.est_heading = p.true_heading;
            end
            default: ;
        endcase
        return p;
    endfunction

    function automatic logic [WL_W-1:0] pick_window();
        case ($urandom_range(0, 9))
            0:       return WL_W'(1);
            1:       return WL_W'(2);
            2:       return WL_W'(WINDOW_DEPTH);
            3:       return WL_W'(0);
            4:       return WL_W'(127);
            5:       return WL_W'($urandom_range(WINDOW_DEPTH + 1, 127));
            default: return WL_W'($urandom_range(3, WINDOW_DEPTH - 1));
        endcase
    endfunction

    task automatic send_pose(t_pose_in p, bit has_known, t_mse_out known);
        int gap;
        pose_if.valid  <= 1'b1;
        pose_if.data   <= p;
        pose_has_known <= has_known;
        pose_known     <= known;
        do @(posedge i_clk); while (!pose_if.ready);
        poses_sent++;
        gap = pose_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            pose_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // block idle: no pose offered, every result in
    task automatic settle_idle();
        if (pose_if.valid)
            pose_if.valid <= 1'b0;
        // the monitor logs a pose taken at this edge before the queue is read
        @(posedge i_clk);
        while (mse_expected.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register write, then read back the window length
    task automatic write_reg_checked(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
        logic [APB_DW-1:0] want;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_WINDOW_LENGTH) begin
            wl_reg     = data[WL_W-1:0];
            write_pos  = 0;
            fill_count = 0;
        end
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_WINDOW_LENGTH;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        want = {{(APB_DW - WL_W){1'b0}}, wl_reg};
        if (prdata !== want) begin
            errors++;
            $display("%0t window_length readback expected %0d got %0d", $time, want, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // monitors
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_mse_out predicted;
        if (i_rst_n && pose_accept) begin
            predicted = predict_window_means(pose_if.data);
            mse_expected.insert(mse_expected.size(), pose_has_known ? pose_known : predicted);
        end
    end

    always @(posedge i_clk) begin
        t_mse_out want;
        if (i_rst_n && mse_accept) begin
            results_seen <= results_seen + 1;
            if (mse_expected.size() == 0) begin
                errors++;
                $display("%0t unexpected result: expected none got pos %0d head %0d",
                         $time, mse_if.data.mean_sq_position_error,
                         mse_if.data.mean_sq_heading_error);
            end else begin
                want = mse_expected.pop_front();
                if (mse_if.data.mean_sq_position_error !== want.mean_sq_position_error) begin
                    errors++;
                    $display("%0t mean_sq_position_error expected %0d got %0d", $time,
                             want.mean_sq_position_error,
                             mse_if.data.mean_sq_position_error);
                end
                if (mse_if.data.mean_sq_heading_error !== want.mean_sq_heading_error) begin
                    errors++;
                    $display("%0t mean_sq_heading_error expected %0d got %0d", $time,
                             want.mean_sq_heading_error,
                             mse_if.data.mean_sq_heading_error);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || pose_accept || mse_accept)
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
    end

    initial begin : watchdog
        wait (stalled_cycles >= WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // result side: random backpressure plus long hold-offs to fill the block
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int burst;
        int gap;
        mse_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (holdoffs_done < 2 && pose_if.valid
                && results_seen >= (holdoffs_done == 0 ? 150 : 600)) begin
                holdoffs_done++;
                mse_if.ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge i_clk);
            end
            mse_if.ready <= 1'b1;
            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 8);
            repeat (burst) @(posedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                mse_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_step           step;
        logic [WL_W-1:0] wl;
        int              n_items;
        int              span;

        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        pose_if.valid  = 1'b0;
        pose_if.data   = '0;
        pose_has_known = 1'b0;
        pose_known     = '0;
        pose_gaps_on   = 1'b1;
        errors         = 0;
        results_seen   = 0;
        holdoffs_done  = 0;
        poses_sent     = 0;
        stalled_cycles = 0;
        wl_reg         = WL_RESET;
        write_pos      = 0;
        fill_count     = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset window of 8: zero error, then extremes both ways
        add_step(pose_row(0, 0, 0, 0, 0, 0, 1'b1, 0, 0));
        add_step(pose_row(POS_MIN, POS_MIN, HEAD_MIN, POS_MAX, POS_MAX, HEAD_MAX,
                          1'b1, 64'd1099509530625, 64'd2147418112));
        add_step(pose_row(POS_MAX, POS_MAX, HEAD_MAX, POS_MIN, POS_MIN, HEAD_MIN,
                          1'b1, 64'd1466012707500, 64'd2863224150));
        add_step(pose_row(1000, -2000, 300, -1000, 2000, -300, 1'b0, 0, 0));
        // window of one: each result is its own squared error
        add_step(reg_row(ADDR_WINDOW_LENGTH, 32'd1));
        add_step(pose_row(POS_MIN, POS_MIN, HEAD_MIN, POS_MAX, POS_MAX, HEAD_MAX,
                          1'b1, 64'd2199019061250, 64'd4294836225));
        add_step(pose_row(123, -77, 5, 123, -77, 5, 1'b1, 0, 0));
        // unmapped register: dropped, window stays one
        add_step(reg_row(ADDR_NO_REG, 32'd3));
        add_step(pose_row(POS_MAX, POS_MAX, HEAD_MAX, POS_MIN, POS_MIN, HEAD_MIN,
                          1'b1, 64'd2199019061250, 64'd4294836225));
        // zero length acts as one
        add_step(reg_row(ADDR_WINDOW_LENGTH, 32'd0));
        add_step(pose_row(3, 0, 0, 0, 0, 0, 1'b1, 9, 0));
        add_step(pose_row(0, 0, 1, 0, 0, -1, 1'b1, 0, 4));
        add_step(pose_row(0, -1000, 0, 0, 1000, 0, 1'b1, 4000000, 0));
        // oversize length saturates, upper data bits ignored
        add_step(reg_row(ADDR_WINDOW_LENGTH, 32'hFFFF_FFFF));
        add_step(pose_row(-1, -1, -1, 0, 0, 0, 1'b0, 0, 0));
        add_step(pose_row(POS_MAX, 0, HEAD_MAX, 0, POS_MIN, 0, 1'b0, 0, 0));
        add_step(pose_row(12345, -54321, 8191, -777, 4242, -8192, 1'b0, 0, 0));
        add_step(reg_row(ADDR_WINDOW_LENGTH, 32'd64));
        add_step(pose_row(262144, -262144, 16384, -1, 1, -16384, 1'b0, 0, 0));
        add_step(pose_row(POS_MIN, POS_MAX, HEAD_MIN, 0, 0, 0, 1'b0, 0, 0));
        // length two: ring wraps on the third pose
        add_step(reg_row(ADDR_WINDOW_LENGTH, 32'd2));
        add_step(pose_row(10, 20, 30, 0, 0, 0, 1'b0, 0, 0));
        add_step(pose_row(-500, 700, -900, 500, -700, 900, 1'b0, 0, 0));
        add_step(pose_row(99999, 5, 1234, -99999, -5, -1234, 1'b0, 0, 0));
        add_step(pose_row(1, 1, 1, 0, 0, 0, 1'b0, 0, 0));

        foreach (directed_steps[k]) begin
            step = directed_steps[k];
            if (step.kind == STEP_REG) begin
                settle_idle();
                write_reg_checked(step.addr, step.wdata);
            end else begin
                send_pose(step.pose, step.has_known, step.known_mse);
            end
        end

        poses_sent = 0;
        while (poses_sent < RANDOM_ITEMS) begin
            settle_idle();
            if ($urandom_range(0, 5) == 0)
                write_reg_checked(ADDR_NO_REG, $urandom);
            wl = pick_window();
            write_reg_checked(ADDR_WINDOW_LENGTH, ($urandom & ~32'h7F) | APB_DW'(wl));
            span = window_span();
            n_items = $urandom_range(1, 2) * span + $urandom_range(0, 20);
            pose_gaps_on = ($urandom_range(0, 3) != 0);
            repeat (n_items) send_pose(rand_pose(), 1'b0, '0);
        end

        settle_idle();
        repeat (END_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
